>>> hw/rtl/mwd_pkg.sv
// mwd_pkg: shared constants, codes and types of the address window decoder
// no dependencies
`timescale 1ns / 1ps

package mwd_pkg;

    localparam int WINDOWS   = 8;
    localparam int SELF_BASE = 4096;
    localparam int SELF_SIZE = 16;

    localparam int ADDR_W = 64;
    localparam int WIN_W  = 32;
    localparam int DEV_W  = 16;
    localparam int IDX_W  = $clog2(WINDOWS);
    localparam int CNT_W  = $clog2(WINDOWS + 1);

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ROUTE_RAM    = 2'd0,
        ROUTE_SELF   = 2'd1,
        ROUTE_DEVICE = 2'd2
    } t_route;

    // snapshot of the window table as seen by the compare logic
    typedef struct packed {
        logic [WINDOWS-1:0]             valid;
        logic [WINDOWS-1:0][WIN_W-1:0]  base;
        logic [WINDOWS-1:0][WIN_W-1:0]  length;
        logic [WINDOWS-1:0][DEV_W-1:0]  owner;
    } t_win_table;

endpackage

>>> hw/rtl/mmio_window_decoder.sv
// mmio_window_decoder: a request goes from the request register through the table compare into the result register
// throughput one request per cycle; busy is never raised, the table compare is single pass
// a table change from one request is visible to the request accepted in the next cycle
// results are strobed for one cycle and cannot be stalled
// synchronous active-low reset: table holds only the own window, no result pending
// depends on mwd_pkg, mwd_table, mwd_match
`timescale 1ns / 1ps

module mmio_window_decoder
    import mwd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_mode,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIN_W-1:0]  i_window_start,
    input  logic [WIN_W-1:0]  i_window_size,
    input  logic [DEV_W-1:0]  i_device_id,
    output logic              o_valid,
    output logic [1:0]        o_route,
    output logic [DEV_W-1:0]  o_target_device,
    output logic [ADDR_W-1:0] o_offset,
    output logic              o_accepted
);

    // request register
    logic              r_req;
    logic [1:0]        r_mode;
    logic [ADDR_W-1:0] r_addr;
    logic [WIN_W-1:0]  r_wstart;
    logic [WIN_W-1:0]  r_wsize;
    logic [DEV_W-1:0]  r_dev;

    // result register
    logic              r_valid;
    logic [1:0]        r_route;
    logic [DEV_W-1:0]  r_tdev;
    logic [ADDR_W-1:0] r_offset;
    logic              r_acc;

    logic              n_valid;
    logic [1:0]        n_route;
    logic [DEV_W-1:0]  n_tdev;
    logic [ADDR_W-1:0] n_offset;
    logic              n_acc;

    logic              tbl_add;
    logic              tbl_clear;
    logic              tbl_full;
    t_win_table        tbl;
    t_route            m_route;
    logic [DEV_W-1:0]  m_tdev;
    logic [ADDR_W-1:0] m_offset;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= 1'b0;
        end else begin
            r_req <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mode   <= i_mode;
            r_addr   <= i_addr;
            r_wstart <= i_window_start;
            r_wsize  <= i_window_size;
            r_dev    <= i_device_id;
        end
    end

    assign tbl_add   = r_req && (t_mode'(r_mode) == MODE_ADD);
    assign tbl_clear = r_req && (t_mode'(r_mode) == MODE_CLEAR);

    mwd_table u_table (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_add          (tbl_add),
        .i_clear        (tbl_clear),
        .i_window_start (r_wstart),
        .i_window_size  (r_wsize),
        .i_device_id    (r_dev),
        .o_full         (tbl_full),
        .o_table        (tbl)
    );

    mwd_match u_match (
        .i_addr          (r_addr),
        .i_table         (tbl),
        .o_route         (m_route),
        .o_target_device (m_tdev),
        .o_offset        (m_offset)
    );

    always_comb begin
        n_valid  = r_req;
        n_route  = ROUTE_RAM;
        n_tdev   = '0;
        n_offset = '0;
        n_acc    = 1'b0;
        case (t_mode'(r_mode))
            MODE_LOOKUP: begin
                n_route  = m_route;
                n_tdev   = m_tdev;
                n_offset = m_offset;
                n_acc    = 1'b1;
            end
            MODE_ADD: begin
                n_acc = !tbl_full;
            end
            MODE_CLEAR: begin
                n_acc = 1'b1;
            end
            default: begin
                // unused mode code: ignored, all fields but valid zero
                n_acc = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req) begin
            r_route  <= n_route;
            r_tdev   <= n_tdev;
            r_offset <= n_offset;
            r_acc    <= n_acc;
        end
    end

    assign o_valid         = r_valid;
    assign o_route         = r_route;
    assign o_target_device = r_tdev;
    assign o_offset        = r_offset;
    assign o_accepted      = r_acc;

endmodule

>>> hw/rtl/mwd_table.sv
// mwd_table: window table storage, append and clear
// depends on mwd_pkg
`timescale 1ns / 1ps

module mwd_table
    import mwd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_add,
    input  logic             i_clear,
    input  logic [WIN_W-1:0] i_window_start,
    input  logic [WIN_W-1:0] i_window_size,
    input  logic [DEV_W-1:0] i_device_id,
    output logic             o_full,
    output t_win_table       o_table
);

    logic [CNT_W-1:0] r_used;
    logic [CNT_W-1:0] n_used;
    logic             wr_en;

    logic [WIN_W-1:0] r_base   [WINDOWS];
    logic [WIN_W-1:0] r_length [WINDOWS];
    logic [DEV_W-1:0] r_owner  [WINDOWS];

    assign o_full = (r_used == CNT_W'(WINDOWS));
    assign wr_en  = i_add && !o_full;

    always_comb begin
        n_used = r_used;
        if (i_clear) begin
            n_used = CNT_W'(1);
        end else if (wr_en) begin
            n_used = r_used + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= CNT_W'(1);
        end else begin
            r_used <= n_used;
        end
    end

    // entry 0 is never written, the count starts at one
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_base[r_used[IDX_W-1:0]]   <= i_window_start;
            r_length[r_used[IDX_W-1:0]] <= i_window_size;
            r_owner[r_used[IDX_W-1:0]]  <= i_device_id;
        end
    end

    always_comb begin
        for (int i = 0; i < WINDOWS; i++) begin
            o_table.valid[i]  = (r_used > CNT_W'(i));
            o_table.base[i]   = r_base[i];
            o_table.length[i] = r_length[i];
            o_table.owner[i]  = r_owner[i];
        end
        // own register window is fixed
        o_table.base[0]   = WIN_W'(SELF_BASE);
        o_table.length[0] = WIN_W'(SELF_SIZE);
        o_table.owner[0]  = '0;
    end

endmodule

>>> hw/rtl/mwd_match.sv
// mwd_match: parallel window compare and first-hit select
// depends on mwd_pkg
`timescale 1ns / 1ps

module mwd_match
    import mwd_pkg::*;
(
    input  logic [ADDR_W-1:0] i_addr,
    input  t_win_table        i_table,
    output t_route            o_route,
    output logic [DEV_W-1:0]  o_target_device,
    output logic [ADDR_W-1:0] o_offset
);

    logic [WINDOWS-1:0]             hit;
    logic [WINDOWS-1:0][ADDR_W-1:0] diff;

    // full-width distance so a window ending past 32 bits still matches
    always_comb begin
        for (int i = 0; i < WINDOWS; i++) begin
            diff[i] = i_addr - ADDR_W'(i_table.base[i]);
            hit[i]  = i_table.valid[i] && (i_addr >= ADDR_W'(i_table.base[i])) &&
                      (diff[i][ADDR_W-1:WIN_W] == '0) &&
                      (diff[i][WIN_W-1:0] < i_table.length[i]);
        end
    end

    // lowest matching entry wins
    always_comb begin
        o_route         = ROUTE_RAM;
        o_target_device = '0;
        o_offset        = i_addr;
        for (int i = WINDOWS - 1; i >= 1; i--) begin
            if (hit[i]) begin
                o_route         = ROUTE_DEVICE;
                o_target_device = i_table.owner[i];
                o_offset        = diff[i];
            end
        end
        if (hit[0]) begin
            o_route         = ROUTE_SELF;
            o_target_device = '0;
            o_offset        = diff[0];
        end
    end

endmodule
